### rtl/core/bb3_pkg.sv
`default_nettype none

package bb3_pkg;

    localparam int RECIP_SHIFT = 18;

    localparam logic [10:0] FW_RESET = 11'd640;
    localparam logic [12:0] FH_RESET = 13'd480;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // red in [23:16], green in [15:8], blue in [7:0]
    typedef logic [23:0] pix_t;

    // 3x3 window, index row*3+col, row 0 oldest, col 0 leftmost
    typedef logic [8:0][23:0] win_t;

    typedef struct packed {
        logic [8:0] mask;
        logic       fend;
    } job_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fend;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX,
        ST_DR1,
        ST_DR2,
        ST_DR3,
        ST_JOB1,
        ST_JOB2
    } state_t;

    // ceil(2^RECIP_SHIFT / (2*n)) for the neighbor counts that occur
    function automatic logic [17:0] recip(input logic [3:0] n);
        logic [17:0] m;
        begin
            case (n)
                4'd1:    m = 18'd131072;
                4'd2:    m = 18'd65536;
                4'd3:    m = 18'd43691;
                4'd4:    m = 18'd32768;
                4'd6:    m = 18'd21846;
                4'd9:    m = 18'd14564;
                default: m = 18'd0;
            endcase
            return m;
        end
    endfunction

    function automatic logic [8:0] make_mask(input logic [2:0] rowsel,
                                             input logic [2:0] colsel);
        logic [8:0] m;
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    m[i*3+j] = rowsel[i] & colsel[j];
                end
            end
            return m;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/box_blur_3x3_rgb_core.sv
`default_nettype none

// 3x3 box blur over an RGB raster stream. Each output word is the half-up rounded
// per-channel mean of the in-frame neighbors of one pixel; result (r-1,c-1) leaves
// on input pixel (r,c), the last column of a row leaves on the row's final pixel,
// and the last row is flushed by one drain word (tuser=1) per column, tlast
// marking the frame's final result. Rows r-2 and r-1 live in one line memory,
// read and written back per pixel. One item is worked at a time: a pixel passes
// through the memory read-modify-write, then issues its results, one or two if
// any, one by one to the mean unit, which holds one job; a drain word does three
// column reads and then issues one result. Downstream stall can hold the issue of
// a result. A config write restarts the frame.
module box_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red, out_green, out_blue
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_wdata
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    bb3_pkg::state_t  state_reg;
    bb3_pkg::state_t  state_next;

    logic [10:0]      fw_reg;
    logic [10:0]      fw_next;
    logic [12:0]      fh_reg;
    logic [12:0]      fh_next;
    logic [12:0]      row_index_reg;
    logic [12:0]      row_index_next;
    logic [10:0]      col_index_reg;
    logic [10:0]      col_index_next;
    logic [10:0]      drain_index_reg;
    logic [10:0]      drain_index_next;
    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    addr_next;
    bb3_pkg::pix_t    pix_reg;
    bb3_pkg::pix_t    pix_next;
    logic [8:0]       mask1_reg;
    logic [8:0]       mask1_next;
    logic [8:0]       mask2_reg;
    logic [8:0]       mask2_next;
    logic             emit1_reg;
    logic             emit1_next;
    logic             emit2_reg;
    logic             emit2_next;
    logic             fend_reg;
    logic             fend_next;
    bb3_pkg::win_t    window_reg;
    bb3_pkg::win_t    window_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    bb3_pkg::result_t out_data_reg;
    bb3_pkg::result_t out_data_next;

    logic [47:0]      line_mem [MAX_WIDTH];
    logic [47:0]      rdata_reg;
    logic             mem_re;
    logic             mem_we;
    logic [AW-1:0]    raddr;
    logic [47:0]      wdata;

    logic [10:0]      w_lim;
    logic [10:0]      w_eff;
    logic [12:0]      h_eff;
    logic             accept;
    logic             pix_ok;
    logic             drn_ok;
    logic             can_issue;
    logic             job_valid;
    bb3_pkg::job_t    job;
    logic             mean_busy;
    bb3_pkg::result_t mean_res;
    logic [11:0]      col_inc;
    logic [13:0]      row_inc;
    logic [11:0]      drn_inc;
    logic [2:0]       rowsel;
    logic             shift_en;

    always_comb
    begin
        w_lim  = (fw_reg == 11'd0) ? 11'd1 : fw_reg;
        w_eff  = ({21'd0, w_lim} > MAX_WIDTH) ? 11'(MAX_WIDTH) : w_lim;
        h_eff  = (fh_reg == 13'd0) ? 13'd1 : fh_reg;
        accept = s_tvalid && s_tready;
        pix_ok = accept && (s_tuser == bb3_pkg::FUNC_PIXEL)
                 && (row_index_reg < h_eff) && (col_index_reg < w_eff);
        drn_ok = accept && (s_tuser == bb3_pkg::FUNC_DRAIN)
                 && (row_index_reg >= h_eff) && (drain_index_reg < w_eff);
        can_issue = !mean_busy && (!out_valid_reg || m_tready);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bb3_pkg::ST_IDLE:
            begin
                if (pix_ok)
                begin
                    state_next = bb3_pkg::ST_PIX;
                end
                else if (drn_ok)
                begin
                    state_next = bb3_pkg::ST_DR1;
                end
            end
            bb3_pkg::ST_PIX:
            begin
                if (emit1_reg)
                begin
                    state_next = bb3_pkg::ST_JOB1;
                end
                else if (emit2_reg)
                begin
                    state_next = bb3_pkg::ST_JOB2;
                end
                else
                begin
                    state_next = bb3_pkg::ST_IDLE;
                end
            end
            bb3_pkg::ST_DR1: state_next = bb3_pkg::ST_DR2;
            bb3_pkg::ST_DR2: state_next = bb3_pkg::ST_DR3;
            bb3_pkg::ST_DR3: state_next = bb3_pkg::ST_JOB1;
            bb3_pkg::ST_JOB1:
            begin
                if (can_issue)
                begin
                    state_next = emit2_reg ? bb3_pkg::ST_JOB2 : bb3_pkg::ST_IDLE;
                end
            end
            bb3_pkg::ST_JOB2:
            begin
                if (can_issue)
                begin
                    state_next = bb3_pkg::ST_IDLE;
                end
            end
            default: state_next = bb3_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        s_tready  = (state_reg == bb3_pkg::ST_IDLE);
        mem_re    = 1'b0;
        raddr     = addr_reg + AW'(1);
        mem_we    = 1'b0;
        shift_en  = 1'b0;
        job_valid = 1'b0;
        job.mask  = mask1_reg;
        job.fend  = fend_reg;
        case (state_reg)
            bb3_pkg::ST_IDLE:
            begin
                mem_re = pix_ok || drn_ok;
                raddr  = (s_tuser == bb3_pkg::FUNC_DRAIN)
                         ? AW'(drain_index_reg) - AW'(1) : AW'(col_index_reg);
            end
            bb3_pkg::ST_PIX:
            begin
                mem_we   = 1'b1;
                shift_en = 1'b1;
            end
            bb3_pkg::ST_DR1,
            bb3_pkg::ST_DR2:
            begin
                mem_re   = 1'b1;
                shift_en = 1'b1;
            end
            bb3_pkg::ST_DR3:
            begin
                shift_en = 1'b1;
            end
            bb3_pkg::ST_JOB1:
            begin
                job_valid = can_issue;
            end
            bb3_pkg::ST_JOB2:
            begin
                job_valid = can_issue;
                job.mask  = mask2_reg;
                job.fend  = 1'b0;
            end
            default:
            begin
                job_valid = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        fw_next          = fw_reg;
        fh_next          = fh_reg;
        row_index_next   = row_index_reg;
        col_index_next   = col_index_reg;
        drain_index_next = drain_index_reg;
        addr_next        = addr_reg;
        pix_next         = pix_reg;
        mask1_next       = mask1_reg;
        mask2_next       = mask2_reg;
        emit1_next       = emit1_reg;
        emit2_next       = emit2_reg;
        fend_next        = fend_reg;
        window_next      = window_reg;
        col_inc          = {1'b0, col_index_reg} + 12'd1;
        row_inc          = {1'b0, row_index_reg} + 14'd1;
        drn_inc          = {1'b0, drain_index_reg} + 12'd1;
        rowsel           = (row_index_reg >= 13'd2) ? 3'b111 : 3'b110;

        if (cfg_we)
        begin
            if (cfg_index == bb3_pkg::REG_FRAME_WIDTH)
            begin
                fw_next = cfg_wdata[10:0];
            end
            else
            begin
                fh_next = cfg_wdata;
            end
            row_index_next   = '0;
            col_index_next   = '0;
            drain_index_next = '0;
        end
        else if (pix_ok)
        begin
            addr_next  = AW'(col_index_reg);
            pix_next   = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
            emit1_next = (row_index_reg != 13'd0) && (col_index_reg != 11'd0);
            emit2_next = (row_index_reg != 13'd0) && (col_index_reg == w_eff - 11'd1);
            fend_next  = 1'b0;
            mask1_next = bb3_pkg::make_mask(rowsel,
                             (col_index_reg >= 11'd2) ? 3'b111 : 3'b110);
            mask2_next = bb3_pkg::make_mask(rowsel,
                             (col_index_reg != 11'd0) ? 3'b110 : 3'b100);
            if (col_inc >= {1'b0, w_eff})
            begin
                col_index_next = '0;
                if (row_inc >= {1'b0, h_eff})
                begin
                    row_index_next   = h_eff;
                    drain_index_next = '0;
                end
                else
                begin
                    row_index_next = row_inc[12:0];
                end
            end
            else
            begin
                col_index_next = col_inc[10:0];
            end
        end
        else if (drn_ok)
        begin
            addr_next  = AW'(drain_index_reg) - AW'(1);
            emit2_next = 1'b0;
            mask1_next = bb3_pkg::make_mask(
                             (h_eff >= 13'd2) ? 3'b011 : 3'b010,
                             {drn_inc < {1'b0, w_eff}, 1'b1, drain_index_reg != 11'd0});
            if (drn_inc >= {1'b0, w_eff})
            begin
                fend_next        = 1'b1;
                row_index_next   = '0;
                col_index_next   = '0;
                drain_index_next = '0;
            end
            else
            begin
                fend_next        = 1'b0;
                drain_index_next = drn_inc[10:0];
            end
        end

        if (mem_re && (state_reg != bb3_pkg::ST_IDLE))
        begin
            addr_next = raddr;
        end

        if (shift_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                window_next[i*3]   = window_reg[i*3+1];
                window_next[i*3+1] = window_reg[i*3+2];
            end
            window_next[2] = rdata_reg[47:24];
            window_next[5] = rdata_reg[23:0];
            window_next[8] = pix_reg;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (mean_busy)
        begin
            out_valid_next = 1'b1;
            out_data_next  = mean_res;
        end
        else if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bb3_pkg::ST_IDLE;
            fw_reg          <= bb3_pkg::FW_RESET;
            fh_reg          <= bb3_pkg::FH_RESET;
            row_index_reg   <= '0;
            col_index_reg   <= '0;
            drain_index_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fw_reg          <= fw_next;
            fh_reg          <= fh_next;
            row_index_reg   <= row_index_next;
            col_index_reg   <= col_index_next;
            drain_index_reg <= drain_index_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        pix_reg      <= pix_next;
        mask1_reg    <= mask1_next;
        mask2_reg    <= mask2_next;
        emit1_reg    <= emit1_next;
        emit2_reg    <= emit2_next;
        fend_reg     <= fend_next;
        window_reg   <= window_next;
        out_data_reg <= out_data_next;
    end

    // line memory: [47:24] row r-2, [23:0] row r-1
    assign wdata = {rdata_reg[23:0], pix_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[addr_reg] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= line_mem[raddr];
        end
    end

    bb3_mean u_mean (
        .clk   (clk),
        .rst_n (rst_n),
        .start (job_valid),
        .job   (job),
        .cells (window_reg),
        .busy  (mean_busy),
        .res   (mean_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.blue, out_data_reg.green, out_data_reg.red};
    assign m_tlast  = out_data_reg.fend;

    // a finished mean never lands on an output word still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        mean_busy |-> !out_valid_reg)
        else $error("mean result landed on a pending output word");

    // write-back goes to the entry read on the previous cycle
    a_rmw_addr: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ($past(mem_re) && ($past(raddr) == addr_reg)))
        else $error("line memory write-back address mismatch");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (row_index_reg <= h_eff) && (col_index_reg < w_eff))
        else $error("row or column index out of frame");

endmodule

`default_nettype wire

### rtl/core/bb3_mean.sv
`default_nettype none

module bb3_mean (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  bb3_pkg::job_t    job,
    input  bb3_pkg::win_t    cells,
    output logic             busy,
    output bb3_pkg::result_t res
);

    logic [11:0] sum_r_next;
    logic [11:0] sum_g_next;
    logic [11:0] sum_b_next;
    logic [3:0]  cnt_next;
    logic [11:0] sum_r_reg;
    logic [11:0] sum_g_reg;
    logic [11:0] sum_b_reg;
    logic [3:0]  cnt_reg;
    logic        fend_reg;
    logic        valid_reg;
    logic [12:0] x_r;
    logic [12:0] x_g;
    logic [12:0] x_b;
    logic [17:0] recip_val;
    logic [30:0] prod_r;
    logic [30:0] prod_g;
    logic [30:0] prod_b;

    // stage 1: masked channel sums
    always_comb
    begin
        sum_r_next = '0;
        sum_g_next = '0;
        sum_b_next = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (job.mask[i])
            begin
                sum_r_next = sum_r_next + 12'(cells[i][23:16]);
                sum_g_next = sum_g_next + 12'(cells[i][15:8]);
                sum_b_next = sum_b_next + 12'(cells[i][7:0]);
            end
        end
        cnt_next = 4'($countones(job.mask));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
            cnt_reg   <= cnt_next;
            fend_reg  <= job.fend;
        end
    end

    // stage 2: (2*sum + n) / (2*n) by reciprocal multiply
    always_comb
    begin
        recip_val = bb3_pkg::recip(cnt_reg);
        x_r       = {sum_r_reg, 1'b0} + 13'(cnt_reg);
        x_g       = {sum_g_reg, 1'b0} + 13'(cnt_reg);
        x_b       = {sum_b_reg, 1'b0} + 13'(cnt_reg);
        prod_r    = 31'(x_r) * 31'(recip_val);
        prod_g    = 31'(x_g) * 31'(recip_val);
        prod_b    = 31'(x_b) * 31'(recip_val);
        res.red   = prod_r[bb3_pkg::RECIP_SHIFT +: 8];
        res.green = prod_g[bb3_pkg::RECIP_SHIFT +: 8];
        res.blue  = prod_b[bb3_pkg::RECIP_SHIFT +: 8];
        res.fend  = fend_reg;
    end

    assign busy = valid_reg;

endmodule

`default_nettype wire

### bench/tb_box_blur_3x3_rgb_core.sv
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgb_core;

    localparam int LINE_DEPTH   = 1024;
    localparam int RANDOM_WORDS = 550;
    localparam int QUIET_CYCLES = 16;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int REPORT_LIMIT = 10;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // in_red, in_green, in_blue
    logic        s_tuser;   // func
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // out_red, out_green, out_blue
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_wdata;

    logic [10:0]      reg_width;
    logic [12:0]      reg_height;
    bb3_pkg::pix_t    older_line [0:LINE_DEPTH-1];
    bb3_pkg::pix_t    newer_line [0:LINE_DEPTH-1];
    bb3_pkg::pix_t    win_cells  [0:8];
    int               row_idx;
    int               col_idx;
    int               drain_idx;
    int               sum_r;
    int               sum_g;
    int               sum_b;
    int               sum_n;
    bb3_pkg::result_t pending_blur [$];
    bb3_pkg::result_t want_word;

    bit          idle_on     = 1'b1;
    int          hold_cycles = 0;
    int          mismatches  = 0;

    box_blur_3x3_rgb_core #(
        .MAX_WIDTH (LINE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int eff_width();
        int w;
        w = int'(reg_width);
        if (w == 0)
            w = 1;
        if (w > LINE_DEPTH)
            w = LINE_DEPTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(reg_height);
        return (h == 0) ? 1 : h;
    endfunction

    function automatic void tally(input bb3_pkg::pix_t p);
        sum_r += int'(p[23:16]);
        sum_g += int'(p[15:8]);
        sum_b += int'(p[7:0]);
        sum_n++;
    endfunction

    function automatic void tally_window(input int rlo, input int clo);
        int rr;
        int cc;
        for (rr = rlo; rr < 3; rr++)
        begin
            for (cc = clo; cc <= 2; cc++)
            begin
                tally(win_cells[rr*3+cc]);
            end
        end
    endfunction

    function automatic logic [7:0] chan_avg(input int sum, input int n);
        int q;
        q = (2 * sum + n) / (2 * n);
        return q[7:0];
    endfunction

    function automatic bb3_pkg::result_t blurred(input logic fend);
        bb3_pkg::result_t res;
        res.red   = chan_avg(sum_r, sum_n);
        res.green = chan_avg(sum_g, sum_n);
        res.blue  = chan_avg(sum_b, sum_n);
        res.fend  = fend;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        sum_n = 0;
        return res;
    endfunction

    task automatic predict_word(input logic func, input logic [7:0] red, green, blue);
        int            w;
        int            h;
        int            r;
        int            c;
        int            lo;
        int            hi;
        int            rlo;
        bb3_pkg::pix_t pix;
        bb3_pkg::pix_t up2;
        bb3_pkg::pix_t up1;
        w = eff_width();
        h = eff_height();
        if (func == bb3_pkg::FUNC_DRAIN)
        begin
            if (row_idx < h || drain_idx >= w)
                return;
            lo = (drain_idx >= 1) ? drain_idx - 1 : drain_idx;
            hi = (drain_idx + 1 < w) ? drain_idx + 1 : drain_idx;
            for (c = lo; c <= hi; c++)
            begin
                if (h >= 2)
                    tally(older_line[c]);
                tally(newer_line[c]);
            end
            drain_idx++;
            if (drain_idx >= w)
            begin
                pending_blur.push_back(blurred(1'b1));
                row_idx   = 0;
                col_idx   = 0;
                drain_idx = 0;
            end
            else
            begin
                pending_blur.push_back(blurred(1'b0));
            end
            return;
        end
        if (row_idx >= h || col_idx >= w)
            return;
        r   = row_idx;
        c   = col_idx;
        pix = {red, green, blue};
        up2 = older_line[c];
        up1 = newer_line[c];
        older_line[c] = up1;
        newer_line[c] = pix;
        for (int i = 0; i < 3; i++)
        begin
            win_cells[i*3]   = win_cells[i*3+1];
            win_cells[i*3+1] = win_cells[i*3+2];
        end
        win_cells[2] = up2;
        win_cells[5] = up1;
        win_cells[8] = pix;
        if (r >= 1)
        begin
            rlo = (r >= 2) ? 0 : 1;
            if (c >= 1)
            begin
                tally_window(rlo, (c >= 2) ? 0 : 1);
                pending_blur.push_back(blurred(1'b0));
            end
            if (c == w - 1)
            begin
                tally_window(rlo, (c >= 1) ? 1 : 2);
                pending_blur.push_back(blurred(1'b0));
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = h;
                drain_idx = 0;
            end
        end
        col_idx = c;
        row_idx = r;
    endtask

    function automatic logic [7:0] rand_chan();
        if ($urandom_range(9) == 0)
            return ($urandom_range(1) == 1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_word(input logic func, input logic [7:0] red, green, blue);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {blue, green, red};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_word(func, red, green, blue);
    endtask

    task automatic send_frame(input int pixels, input int drains);
        repeat (pixels)
            send_word(bb3_pkg::FUNC_PIXEL, rand_chan(), rand_chan(), rand_chan());
        repeat (drains)
            send_word(bb3_pkg::FUNC_DRAIN, rand_chan(), rand_chan(), rand_chan());
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == bb3_pkg::REG_FRAME_WIDTH)
            reg_width = value[10:0];
        else
            reg_height = value;
        row_idx   = 0;
        col_idx   = 0;
        drain_idx = 0;
    endtask

    // let outstanding words and any result-less item in flight finish
    task automatic wait_quiet();
        int n;
        @(negedge clk);
        s_tvalid <= 1'b0;
        n = 0;
        while (pending_blur.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (QUIET_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_frame(input logic [12:0] w, input logic [12:0] h);
        wait_quiet();
        write_reg(bb3_pkg::REG_FRAME_WIDTH, w);
        write_reg(bb3_pkg::REG_FRAME_HEIGHT, h);
    endtask

    task automatic test_basic_frame();
        set_frame(13'h1803, 13'd2);   // width 3, upper bits dropped
        send_word(bb3_pkg::FUNC_PIXEL, 8'd0,   8'd0,   8'd0);
        send_word(bb3_pkg::FUNC_PIXEL, 8'd255, 8'd255, 8'd255);
        send_word(bb3_pkg::FUNC_PIXEL, 8'd255, 8'd0,   8'd128);
        send_word(bb3_pkg::FUNC_DRAIN, 8'd255, 8'd255, 8'd255);   // too early
        send_word(bb3_pkg::FUNC_PIXEL, 8'd0,   8'd255, 8'd0);
        send_word(bb3_pkg::FUNC_PIXEL, 8'd128, 8'd128, 8'd128);
        send_word(bb3_pkg::FUNC_PIXEL, 8'd1,   8'd254, 8'd127);
        send_word(bb3_pkg::FUNC_PIXEL, 8'd77,  8'd88,  8'd99);    // ignored while draining
        send_word(bb3_pkg::FUNC_DRAIN, 8'd0,   8'd0,   8'd0);
        send_word(bb3_pkg::FUNC_DRAIN, 8'd255, 8'd255, 8'd255);
        send_word(bb3_pkg::FUNC_DRAIN, 8'd170, 8'd85,  8'd51);
        send_word(bb3_pkg::FUNC_DRAIN, 8'd0,   8'd0,   8'd0);     // next frame not started
        send_word(bb3_pkg::FUNC_PIXEL, 8'd255, 8'd255, 8'd255);
    endtask

    task automatic test_unit_frames();
        set_frame(13'd0, 13'd0);
        send_frame(1, 1);
        set_frame(13'd1, 13'd3);
        send_frame(3, 1);
        set_frame(13'd4, 13'd1);
        send_frame(4, 4);
    endtask

    task automatic test_restart();
        set_frame(13'd5, 13'd3);
        send_frame(7, 0);
        wait_quiet();
        write_reg(bb3_pkg::REG_FRAME_WIDTH, 13'd5);
        send_frame(15, 2);
        wait_quiet();
        write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'd3);
        send_frame(15, 5);
    endtask

    task automatic test_size_extremes();
        // width clips to the line depth, so the second row starts after 1024 pixels
        set_frame(13'd2047, 13'd2);
        send_frame(1030, 0);
        set_frame(13'd1, 13'h1FFF);
        send_frame(100, 0);
        set_frame(13'd1024, 13'd1);
        send_frame(40, 0);
    endtask

    task automatic test_backpressure();
        set_frame(13'd8, 13'd4);
        hold_cycles = 500;
        send_frame(32, 8);
    endtask

    task automatic test_random_frames();
        int          sent;
        int          frame;
        int          w;
        int          h;
        int          npix;
        int          total;
        int          cut;
        bit          last_full;
        logic [12:0] wv;
        logic [12:0] hv;
        sent      = 0;
        frame     = 0;
        last_full = 1'b0;
        while (sent < RANDOM_WORDS)
        begin
            idle_on = (frame < 3 || frame >= 8);
            if (!(last_full && $urandom_range(3) == 0))
            begin
                w = ($urandom_range(7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
                h = ($urandom_range(7) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
                wv = 13'(w);
                wv[12:11] = 2'($urandom_range(3));
                if (w == 1 && $urandom_range(1) == 1)
                    wv[10:0] = '0;
                hv = 13'(h);
                if (h == 1 && $urandom_range(1) == 1)
                    hv = '0;
                set_frame(wv, hv);
            end
            npix  = eff_width() * eff_height();
            total = npix + eff_width();
            cut   = ($urandom_range(9) == 0) ? $urandom_range(1, total - 1) : total;
            for (int k = 0; k < cut; k++)
            begin
                if ($urandom_range(24) == 0)
                    send_word((k < npix) ? bb3_pkg::FUNC_DRAIN : bb3_pkg::FUNC_PIXEL,
                              rand_chan(), rand_chan(), rand_chan());
                send_word((k < npix) ? bb3_pkg::FUNC_PIXEL : bb3_pkg::FUNC_DRAIN,
                          rand_chan(), rand_chan(), rand_chan());
                sent++;
            end
            last_full = (cut == total);
            frame++;
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles - 1)
                    @(negedge clk);
                hold_cycles = 0;
            end
            else
            begin
                m_tready <= !(idle_on && $urandom_range(99) < 34);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_blur.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected word: r=%0d g=%0d b=%0d last=%0b",
                             m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast);
                mismatches++;
            end
            else
            begin
                want_word = pending_blur.pop_front();
                if (m_tdata[7:0] !== want_word.red || m_tdata[15:8] !== want_word.green ||
                    m_tdata[23:16] !== want_word.blue || m_tlast !== want_word.fend)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display({"mismatch: exp r=%0d g=%0d b=%0d last=%0b, ",
                                  "got r=%0d g=%0d b=%0d last=%0b"},
                                 want_word.red, want_word.green, want_word.blue,
                                 want_word.fend, m_tdata[7:0], m_tdata[15:8],
                                 m_tdata[23:16], m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = bb3_pkg::FUNC_PIXEL;
        cfg_we    = 1'b0;
        cfg_index = bb3_pkg::REG_FRAME_WIDTH;
        cfg_wdata = '0;
        reg_width  = bb3_pkg::FW_RESET;
        reg_height = bb3_pkg::FH_RESET;
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            win_cells[i] = '0;
        row_idx   = 0;
        col_idx   = 0;
        drain_idx = 0;
        sum_r     = 0;
        sum_g     = 0;
        sum_b     = 0;
        sum_n     = 0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_frame();
        test_unit_frames();
        test_restart();
        test_size_extremes();
        test_backpressure();
        test_random_frames();
        wait_quiet();

        if (pending_blur.size() != 0)
        begin
            $display("%0d expected words never arrived", pending_blur.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
